// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the register access master; the sequencer file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/i2cram_pkg.sv =====
// Package with the item types and constants of the register access master.
`default_nettype none

package i2cram_pkg;

    // One timing tick as it moves from the front queue to the sequencer
    typedef struct packed {
        logic       start_request;
        logic       operation;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic       sda_in;
    } t_tick;

    // One result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_res;

    // Device address after reset
    localparam logic [6:0] DEV_ADDR_RST = 7'd104;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Sequencer phases
    localparam logic [3:0] P_IDLE    = 4'd0;
    localparam logic [3:0] P_START   = 4'd1;
    localparam logic [3:0] P_DEVW    = 4'd2;
    localparam logic [3:0] P_ACK_A   = 4'd3;
    localparam logic [3:0] P_REG     = 4'd4;
    localparam logic [3:0] P_ACK_B   = 4'd5;
    localparam logic [3:0] P_DATA    = 4'd6;
    localparam logic [3:0] P_STOP    = 4'd7;
    localparam logic [3:0] P_RESTART = 4'd8;
    localparam logic [3:0] P_DEVR    = 4'd9;
    localparam logic [3:0] P_ACK_C   = 4'd10;
    localparam logic [3:0] P_RECV    = 4'd11;

endpackage

`default_nettype wire

// ===== sv/i2cram_ifs.sv =====
// Valid/ready channel interfaces for ticks and results.
`default_nettype none

interface i2cram_tick_if;
    logic       valid;
    logic       ready;
    logic       start_request;
    logic       operation;
    logic [7:0] reg_index;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, start_request, operation, reg_index, write_data, sda_in,
                    input ready);
    modport sink (input valid, start_request, operation, reg_index, write_data, sda_in,
                  output ready);
endinterface

interface i2cram_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_missing, input ready);
    modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, ack_missing, output ready);
endinterface

`default_nettype wire

// ===== sv/i2c_register_access_master.sv =====
// A taken tick waits in the tick queue, then the sequencer steps on it and loads its result into the output register.
// Throughput: one tick per cycle while the output register can take the result; one bus step per tick taken.
// A two-entry tick queue parts the input from the sequencer, an output register the results.
// Reset (synchronous, active low): idle phase, both lines high and driven, flags cleared,
// device address 104; no clearing pass, the block takes ticks as soon as reset is released.
`default_nettype none

module i2c_register_access_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [6:0]        i_cfg_wdata,
    i2cram_tick_if.sink      i_tick,
    i2cram_res_if.source     o_res
);

    i2cram_pkg::t_tick in_data;
    i2cram_pkg::t_tick q_data;
    i2cram_pkg::t_res  res;
    logic              q_valid, q_ready;

    // Pack the incoming tick
    assign in_data.start_request = i_tick.start_request;
    assign in_data.operation     = i_tick.operation;
    assign in_data.reg_index     = i_tick.reg_index;
    assign in_data.write_data    = i_tick.write_data;
    assign in_data.sda_in        = i_tick.sda_in;

    i2cram_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tick.valid),
        .o_ready (i_tick.ready),
        .i_data  (in_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    i2cram_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_data      (q_data),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_res       (res)
    );

    // Unpack the result
    assign o_res.scl_level   = res.scl_level;
    assign o_res.sda_level   = res.sda_level;
    assign o_res.sda_drive   = res.sda_drive;
    assign o_res.busy_res    = res.busy_res;
    assign o_res.done_res    = res.done_res;
    assign o_res.read_data   = res.read_data;
    assign o_res.ack_missing = res.ack_missing;

endmodule

`default_nettype wire

// ===== sv/i2cram_front.sv =====
// Front end: accepts ticks and holds them in a short queue for the sequencer.
`default_nettype none

module i2cram_front #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  i2cram_pkg::t_tick   i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output i2cram_pkg::t_tick   o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    i2cram_pkg::t_tick r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push, pop;

    // Accept while a slot is free
    assign o_ready = (r_count < CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers with wrap, track fill
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cram_seq.sv =====
// Back end: bus sequencer that turns each tick into line levels and status.
`default_nettype none
`include "assert_macros.svh"

module i2cram_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [6:0]           i_cfg_wdata,
    input  wire                 i_valid,
    output logic                o_ready,
    input  i2cram_pkg::t_tick   i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output i2cram_pkg::t_res    o_res
);

    logic [6:0]  r_dev_addr;
    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_step, n_step;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [16:0] r_lat, n_lat;
    logic [7:0]  r_rcv, n_rcv;
    logic        r_ack, n_ack;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drv, n_drv;
    logic        r_out_valid;
    i2cram_pkg::t_res r_res;

    logic        fire, launch, busy, done, go;
    logic [3:0]  ph, go_ph;
    logic [2:0]  st, bt;

    // Step once per tick while the output register can take the result
    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;
    assign launch  = (r_phase == i2cram_pkg::P_IDLE) && i_data.start_request;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // Compute one bus step
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_lat   = r_lat;
        n_rcv   = r_rcv;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        done    = 1'b0;
        go      = 1'b0;
        go_ph   = i2cram_pkg::P_IDLE;

        // Latch a new request; this tick is its first
        if (launch) begin
            n_lat   = {i_data.operation, i_data.reg_index, i_data.write_data};
            n_ack   = 1'b0;
            n_phase = i2cram_pkg::P_START;
            n_step  = 3'd0;
            n_bit   = 3'd0;
        end
        ph   = launch ? i2cram_pkg::P_START : r_phase;
        st   = launch ? 3'd0 : r_step;
        bt   = launch ? 3'd0 : r_bit;
        busy = (ph != i2cram_pkg::P_IDLE);

        case (ph)
            i2cram_pkg::P_IDLE: begin
            end
            i2cram_pkg::P_START, i2cram_pkg::P_RESTART: begin
                if (st == 3'd1) begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                    n_drv = 1'b1;
                end else if (st == 3'd2) begin
                    n_sda = 1'b0;
                    n_drv = 1'b1;
                end
                if (st >= 3'd2) begin
                    go    = 1'b1;
                    go_ph = (ph == i2cram_pkg::P_START) ? i2cram_pkg::P_DEVW
                                                        : i2cram_pkg::P_DEVR;
                end else begin
                    n_step = st + 3'd1;
                end
            end
            i2cram_pkg::P_DEVW, i2cram_pkg::P_REG, i2cram_pkg::P_DATA,
            i2cram_pkg::P_DEVR: begin
                case (st)
                    3'd0: if (bt != 3'd0) n_scl = 1'b0;
                    3'd1: n_scl = 1'b0;
                    3'd2: begin
                        n_drv = 1'b1;
                        n_sda = r_shift[3'd7 - bt];
                    end
                    3'd3: n_scl = 1'b1;
                    default: n_scl = 1'b0;
                endcase
                if (st < 3'd3) begin
                    n_step = st + 3'd1;
                end else if (st == 3'd3) begin
                    if (bt < 3'd7) begin
                        n_bit  = bt + 3'd1;
                        n_step = 3'd0;
                    end else begin
                        n_step = 3'd4;
                    end
                end else begin
                    go = 1'b1;
                    case (ph)
                        i2cram_pkg::P_DEVW: go_ph = i2cram_pkg::P_ACK_A;
                        i2cram_pkg::P_REG:  go_ph = i2cram_pkg::P_ACK_B;
                        i2cram_pkg::P_DEVR: go_ph = i2cram_pkg::P_ACK_C;
                        default:            go_ph = i2cram_pkg::P_STOP;
                    endcase
                end
            end
            i2cram_pkg::P_ACK_A, i2cram_pkg::P_ACK_B, i2cram_pkg::P_ACK_C: begin
                case (st)
                    3'd1: begin
                        n_sda = 1'b1;
                        n_drv = 1'b0;
                    end
                    3'd2: n_scl = 1'b0;
                    3'd3: n_scl = 1'b1;
                    3'd4: begin
                        n_sda = 1'b1;
                        n_drv = 1'b0;
                        if (i_data.sda_in) n_ack = 1'b1;
                    end
                    3'd6: n_scl = 1'b0;
                    default: begin
                    end
                endcase
                if (st < 3'd6) begin
                    n_step = st + 3'd1;
                end else begin
                    go = 1'b1;
                    if (ph == i2cram_pkg::P_ACK_A) begin
                        go_ph = i2cram_pkg::P_REG;
                    end else if (ph == i2cram_pkg::P_ACK_B) begin
                        go_ph = (n_lat[16] == i2cram_pkg::OP_READ) ? i2cram_pkg::P_RESTART
                                                                   : i2cram_pkg::P_DATA;
                    end else begin
                        go_ph = i2cram_pkg::P_RECV;
                    end
                end
            end
            i2cram_pkg::P_RECV: begin
                case (st)
                    3'd0: if (bt != 3'd0) n_scl = 1'b0;
                    3'd1: n_scl = 1'b0;
                    3'd2: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_drv = 1'b0;
                    end
                    3'd3: begin
                        n_sda   = 1'b1;
                        n_drv   = 1'b0;
                        n_shift = {r_shift[6:0], i_data.sda_in};
                    end
                    3'd4: begin
                    end
                    default: begin
                        n_scl = 1'b0;
                        n_rcv = r_shift;
                    end
                endcase
                if (st < 3'd4) begin
                    n_step = st + 3'd1;
                end else if (st == 3'd4) begin
                    if (bt < 3'd7) begin
                        n_bit  = bt + 3'd1;
                        n_step = 3'd0;
                    end else begin
                        n_step = 3'd5;
                    end
                end else begin
                    go    = 1'b1;
                    go_ph = i2cram_pkg::P_STOP;
                end
            end
            i2cram_pkg::P_STOP: begin
                case (st)
                    3'd1: n_scl = 1'b1;
                    3'd2: n_scl = 1'b0;
                    3'd3: begin
                        n_sda = 1'b0;
                        n_drv = 1'b1;
                    end
                    3'd4: n_scl = 1'b1;
                    3'd5: begin
                        n_sda = 1'b1;
                        n_drv = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (st < 3'd5) begin
                    n_step = st + 3'd1;
                end else begin
                    go    = 1'b1;
                    go_ph = i2cram_pkg::P_IDLE;
                    done  = 1'b1;
                end
            end
            default: begin
                go    = 1'b1;
                go_ph = i2cram_pkg::P_IDLE;
                busy  = 1'b0;
            end
        endcase

        // Enter the next phase and load its shift byte
        if (go) begin
            n_phase = go_ph;
            n_step  = 3'd0;
            n_bit   = 3'd0;
            case (go_ph)
                i2cram_pkg::P_DEVW: n_shift = {r_dev_addr, 1'b0};
                i2cram_pkg::P_REG:  n_shift = n_lat[15:8];
                i2cram_pkg::P_DATA: n_shift = n_lat[7:0];
                i2cram_pkg::P_DEVR: n_shift = {r_dev_addr, 1'b1};
                i2cram_pkg::P_RECV: n_shift = 8'd0;
                default: begin
                end
            endcase
        end
    end

    // Hold the device address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= i2cram_pkg::DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // Update sequencer state on each tick taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cram_pkg::P_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_lat   <= '0;
            r_rcv   <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (fire) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_lat   <= n_lat;
            r_rcv   <= n_rcv;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    // Output register: drop on take, load on step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res.scl_level   <= n_scl;
            r_res.sda_level   <= n_drv ? n_sda : 1'b1;
            r_res.sda_drive   <= n_drv;
            r_res.busy_res    <= busy;
            r_res.done_res    <= done;
            r_res.read_data   <= n_rcv;
            r_res.ack_missing <= n_ack;
        end
    end

    `AST_CLK(a_done_to_idle, i_clk, i_rst_n, fire && done |=> r_phase == i2cram_pkg::P_IDLE, "done without return to idle")
    `AST_CLK(a_no_step_when_full, i_clk, i_rst_n, r_out_valid && !i_ready |-> !fire, "step while result waits")
    `AST_CLK(a_idle_stays, i_clk, i_rst_n, fire && r_phase == i2cram_pkg::P_IDLE && !i_data.start_request |=> r_phase == i2cram_pkg::P_IDLE, "left idle without request")
    `AST_ALWAYS(a_reset_lines, i_clk, !i_rst_n |=> r_scl && r_sda && r_drv && !r_out_valid, "lines not released by reset")

endmodule

`default_nettype wire

// ===== tb/i2c_register_access_master_tb.sv =====
// Testbench for the I2C register access master: random bus ticks checked against a line predictor.
`timescale 1ns / 1ps

module i2c_register_access_master_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_TICKS  = 100;
    localparam int MAX_PRINTED  = 200;

    // How the sender models the data line seen by the master
    typedef enum {SDA_ACK_OK, SDA_NOISE, SDA_ALL_LOW, SDA_ALL_HIGH} t_sda_mode;

    // Predict bus lines and status per tick, hold the expected results, compare
    class t_line_checker;
        i2cram_pkg::t_res expected_lines[$];
        int          mismatches;
        int          checked;
        logic [6:0]  dev_addr;
        logic [3:0]  phase;
        int          step;
        int          bit_idx;
        logic [7:0]  shift_byte;
        logic        req_op;
        logic [7:0]  req_reg;
        logic [7:0]  req_data;
        logic [7:0]  rx_byte;
        logic        ack_err;
        logic        scl;
        logic        sda;
        logic        sda_drv;

        function new();
            mismatches = 0;
            checked    = 0;
            dev_addr   = i2cram_pkg::DEV_ADDR_RST;
            phase      = i2cram_pkg::P_IDLE;
            step       = 0;
            bit_idx    = 0;
            shift_byte = '0;
            req_op     = i2cram_pkg::OP_WRITE;
            req_reg    = '0;
            req_data   = '0;
            rx_byte    = '0;
            ack_err    = 1'b0;
            scl        = 1'b1;
            sda        = 1'b1;
            sda_drv    = 1'b1;
        endfunction

        // Load the byte that a send phase shifts out
        function void enter_phase(logic [3:0] p);
            phase   = p;
            step    = 0;
            bit_idx = 0;
            case (p)
                i2cram_pkg::P_DEVW: shift_byte = {dev_addr, 1'b0};
                i2cram_pkg::P_REG:  shift_byte = req_reg;
                i2cram_pkg::P_DATA: shift_byte = req_data;
                i2cram_pkg::P_DEVR: shift_byte = {dev_addr, 1'b1};
                default: ;
            endcase
        endfunction

        function void drive_sda(logic v);
            sda_drv = 1'b1;
            sda     = v;
        endfunction

        function void release_sda();
            sda     = 1'b1;
            sda_drv = 1'b0;
        endfunction

        // Advance the sequencer by one accepted tick and queue its result
        function void note_tick(i2cram_pkg::t_tick t);
            i2cram_pkg::t_res r;
            logic busy;
            logic done;
            done = 1'b0;
            if (phase == i2cram_pkg::P_IDLE && t.start_request) begin
                req_op   = t.operation;
                req_reg  = t.reg_index;
                req_data = t.write_data;
                ack_err  = 1'b0;
                enter_phase(i2cram_pkg::P_START);
            end
            busy = (phase != i2cram_pkg::P_IDLE);

            case (phase)
                i2cram_pkg::P_IDLE: ;
                i2cram_pkg::P_START, i2cram_pkg::P_RESTART: begin
                    if (step == 1) begin
                        scl = 1'b1;
                        drive_sda(1'b1);
                    end else if (step == 2) begin
                        drive_sda(1'b0);
                    end
                    if (step >= 2)
                        enter_phase(phase == i2cram_pkg::P_START ? i2cram_pkg::P_DEVW
                                                                 : i2cram_pkg::P_DEVR);
                    else step++;
                end
                i2cram_pkg::P_DEVW, i2cram_pkg::P_REG, i2cram_pkg::P_DATA,
                i2cram_pkg::P_DEVR: begin
                    case (step)
                        0: if (bit_idx > 0) scl = 1'b0;
                        1: scl = 1'b0;
                        2: drive_sda(shift_byte[7 - bit_idx]);
                        3: scl = 1'b1;
                        default: scl = 1'b0;
                    endcase
                    if (step < 3) begin
                        step++;
                    end else if (step == 3) begin
                        if (bit_idx < 7) begin
                            bit_idx++;
                            step = 0;
                        end else begin
                            step = 4;
                        end
                    end else begin
                        enter_phase(phase == i2cram_pkg::P_DEVW ? i2cram_pkg::P_ACK_A :
                                    phase == i2cram_pkg::P_REG  ? i2cram_pkg::P_ACK_B :
                                    phase == i2cram_pkg::P_DEVR ? i2cram_pkg::P_ACK_C :
                                                                  i2cram_pkg::P_STOP);
                    end
                end
                i2cram_pkg::P_ACK_A, i2cram_pkg::P_ACK_B, i2cram_pkg::P_ACK_C: begin
                    case (step)
                        1: release_sda();
                        2: scl = 1'b0;
                        3: scl = 1'b1;
                        4: begin
                            release_sda();
                            if (t.sda_in) ack_err = 1'b1;
                        end
                        6: scl = 1'b0;
                        default: ;
                    endcase
                    if (step < 6) begin
                        step++;
                    end else if (phase == i2cram_pkg::P_ACK_A) begin
                        enter_phase(i2cram_pkg::P_REG);
                    end else if (phase == i2cram_pkg::P_ACK_B) begin
                        enter_phase(req_op == i2cram_pkg::OP_READ ? i2cram_pkg::P_RESTART
                                                                  : i2cram_pkg::P_DATA);
                    end else begin
                        shift_byte = '0;
                        enter_phase(i2cram_pkg::P_RECV);
                    end
                end
                i2cram_pkg::P_RECV: begin
                    case (step)
                        0: if (bit_idx > 0) scl = 1'b0;
                        1: scl = 1'b0;
                        2: begin
                            scl = 1'b1;
                            release_sda();
                        end
                        3: begin
                            release_sda();
                            shift_byte = {shift_byte[6:0], t.sda_in};
                        end
                        4: ;
                        default: begin
                            scl     = 1'b0;
                            rx_byte = shift_byte;
                        end
                    endcase
                    if (step < 4) begin
                        step++;
                    end else if (step == 4) begin
                        if (bit_idx < 7) begin
                            bit_idx++;
                            step = 0;
                        end else begin
                            step = 5;
                        end
                    end else begin
                        enter_phase(i2cram_pkg::P_STOP);
                    end
                end
                i2cram_pkg::P_STOP: begin
                    case (step)
                        1: scl = 1'b1;
                        2: scl = 1'b0;
                        3: drive_sda(1'b0);
                        4: scl = 1'b1;
                        5: drive_sda(1'b1);
                        default: ;
                    endcase
                    if (step < 5) begin
                        step++;
                    end else begin
                        enter_phase(i2cram_pkg::P_IDLE);
                        done = 1'b1;
                    end
                end
                default: begin
                    enter_phase(i2cram_pkg::P_IDLE);
                    busy = 1'b0;
                end
            endcase

            r.scl_level   = scl;
            r.sda_level   = sda_drv ? sda : 1'b1;
            r.sda_drive   = sda_drv;
            r.busy_res    = busy;
            r.done_res    = done;
            r.read_data   = rx_byte;
            r.ack_missing = ack_err;
            expected_lines.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h expected %0h", checked, name, got, want));
        endtask

        // Compare one accepted result against the oldest expectation
        task check_result(i2cram_pkg::t_res got);
            i2cram_pkg::t_res want;
            checked++;
            if (expected_lines.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
                want = expected_lines.pop_front();
                compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
                compare_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
                compare_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
                compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
                compare_field("read_data", got.read_data, want.read_data);
                compare_field("ack_missing", 8'(got.ack_missing), 8'(want.ack_missing));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    int unsigned cycles = 0;
    int unsigned stim_ticks = 0;
    bit          calm = 1'b0;

    i2cram_tick_if tick_ch();
    i2cram_res_if  res_ch();

    t_line_checker line_chk = new();

    i2c_register_access_master DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (tick_ch),
        .o_res       (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item, hold it until taken, then advance the predictor
    task send_tick(i2cram_pkg::t_tick t);
        while (!calm && $urandom_range(99) < 9) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.start_request <= t.start_request;
        tick_ch.operation     <= t.operation;
        tick_ch.reg_index     <= t.reg_index;
        tick_ch.write_data    <= t.write_data;
        tick_ch.sda_in        <= t.sda_in;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        line_chk.note_tick(t);
    endtask

    // Run one transaction from its start tick until the stop completes
    task run_transfer(logic op, logic [7:0] reg_a, logic [7:0] data, t_sda_mode mode,
                      bit nag);
        i2cram_pkg::t_tick t;
        int    n_idle;
        t.start_request = 1'b1;
        t.operation     = op;
        t.reg_index     = reg_a;
        t.write_data    = data;
        t.sda_in        = 1'($urandom_range(1));
        do begin
            send_tick(t);
            stim_ticks++;
            // Requests while busy are ignored; mix them in as noise
            t.start_request = nag ? 1'b1 : 1'($urandom_range(99) < 15);
            t.operation     = 1'($urandom_range(1));
            t.reg_index     = 8'($urandom);
            t.write_data    = 8'($urandom);
            case (mode)
                SDA_ALL_LOW:  t.sda_in = 1'b0;
                SDA_ALL_HIGH: t.sda_in = 1'b1;
                SDA_ACK_OK: begin
                    if (line_chk.phase inside {i2cram_pkg::P_ACK_A, i2cram_pkg::P_ACK_B,
                                               i2cram_pkg::P_ACK_C} && line_chk.step == 4)
                        t.sda_in = 1'b0;
                    else
                        t.sda_in = 1'($urandom_range(1));
                end
                default: t.sda_in = 1'($urandom_range(1));
            endcase
        end while (line_chk.phase != i2cram_pkg::P_IDLE);

        // Trail with a few idle ticks, sometimes none
        n_idle = $urandom_range(3);
        repeat (n_idle) begin
            t.start_request = 1'b0;
            send_tick(t);
        end
    endtask

    // Stop offering and wait for every expected result
    task drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (line_chk.expected_lines.size() != 0) @(posedge i_clk);
    endtask

    task write_dev_addr(logic [6:0] addr);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= addr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        line_chk.dev_addr = addr;
    endtask

    // Accept results with random stalls and one long hold-off
    initial begin
        i2cram_pkg::t_res got;
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
                got = {res_ch.scl_level, res_ch.sda_level, res_ch.sda_drive, res_ch.busy_res,
                       res_ch.done_res, res_ch.read_data, res_ch.ack_missing};
                line_chk.check_result(got);
            end
            if (!held && line_chk.checked >= 1000 && tick_ch.valid === 1'b1) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // Reset, directed transactions, random phases, then wrap up
    initial begin
        i2cram_pkg::t_tick idle_tick;
        t_sda_mode   mode;
        int unsigned goal;
        int unsigned pick;
        logic [6:0]  addr;

        tick_ch.valid         <= 1'b0;
        tick_ch.start_request <= 1'b0;
        tick_ch.operation     <= i2cram_pkg::OP_WRITE;
        tick_ch.reg_index     <= '0;
        tick_ch.write_data    <= '0;
        tick_ch.sda_in        <= 1'b1;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        i_rst_n               <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks with every other field high do nothing
        idle_tick = '{1'b0, i2cram_pkg::OP_READ, 8'hFF, 8'hFF, 1'b1};
        repeat (3) send_tick(idle_tick);

        run_transfer(i2cram_pkg::OP_WRITE, 8'h00, 8'h00, SDA_ALL_LOW, 1'b0);
        // Requests on every busy tick must be dropped
        run_transfer(i2cram_pkg::OP_WRITE, 8'hFF, 8'hFF, SDA_ACK_OK, 1'b1);
        // Missing acknowledges and an all-ones byte on read
        run_transfer(i2cram_pkg::OP_READ, 8'h00, 8'hA5, SDA_ALL_HIGH, 1'b0);
        run_transfer(i2cram_pkg::OP_READ, 8'hFF, 8'h00, SDA_ALL_LOW, 1'b0);
        // Write data byte is never acknowledge-checked
        run_transfer(i2cram_pkg::OP_WRITE, 8'h5A, 8'hC3, SDA_ALL_HIGH, 1'b0);
        run_transfer(i2cram_pkg::OP_READ, 8'h3C, 8'h00, SDA_ACK_OK, 1'b0);

        // Random phases, each with its own device address
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: addr = 7'h00;
                1: addr = 7'h7F;
                3: addr = i2cram_pkg::DEV_ADDR_RST;
                default: addr = 7'($urandom);
            endcase
            write_dev_addr(addr);
            calm = (ph == 2);
            goal = stim_ticks + PHASE_TICKS;
            while (stim_ticks < goal) begin
                pick = $urandom_range(99);
                if (pick < 75)      mode = SDA_ACK_OK;
                else if (pick < 85) mode = SDA_NOISE;
                else if (pick < 93) mode = SDA_ALL_LOW;
                else                mode = SDA_ALL_HIGH;
                run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom), mode,
                             $urandom_range(9) == 0);
            end
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (line_chk.mismatches == 0 && line_chk.expected_lines.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
